FILE: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Types, constants and helper functions shared by the key/value tokenizer.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KEY_CAPACITY   = 128;
	localparam int VALUE_CAPACITY = 256;

	localparam int KeyLenW = $clog2(KEY_CAPACITY);
	localparam int ValLenW = $clog2(VALUE_CAPACITY);

	// Result kinds.
	localparam logic [1:0] KIND_KEY     = 2'd0;
	localparam logic [1:0] KIND_VALUE   = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       run_last;
	} token_t;

	// Results produced by one byte, handed from the parser to the queue.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic [7:0] translate(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b == CH_N)
			r = CH_LF;
		else if (b == CH_T)
			r = CH_TAB;
		else if (b == CH_R)
			r = CH_CR;
		return r;
	endfunction

endpackage

FILE: design/key_value_tokenizer.sv
// ----------------------------------------------------------------------------
// key_value_tokenizer
// Splits a command-line byte stream into key bytes, value bytes and markers.
// ----------------------------------------------------------------------------
// One byte is taken per clock while byte_stall is low. Each accepted byte
// waits in an input register until the queue has room, then the parser
// writes its zero, one or two results into a four-entry result queue. A
// byte moves on whenever the queue has room for two results, so the input
// runs at one byte per cycle as long as the output side takes one result
// per cycle; bytes that yield two results (a key or value byte plus its
// end marker) can only drain at the output rate of one result per cycle.
// A byte passes the input register and its results the queue. No clearing pass is needed after reset.
module key_value_tokenizer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  kvt_pkg::item_t  byte_data,
	output logic            tok_valid,
	input  logic            tok_stall,
	output kvt_pkg::token_t tok_data
);

	kvt_pkg::item_t item_s1;
	logic           item_valid_s1;
	logic           advance;
	logic           room;
	kvt_pkg::push_t push;

	assign advance    = item_valid_s1 && room;
	assign byte_stall = item_valid_s1 && !room;

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			item_s1 <= byte_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (!byte_stall)
			item_valid_s1 <= byte_valid;
	end

	kvt_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.push    (push)
	);

	kvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

endmodule

FILE: design/kvt_parser.sv
// ----------------------------------------------------------------------------
// kvt_parser
// Parse state and the per-byte decision logic; emits up to two results.
// ----------------------------------------------------------------------------
module kvt_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  kvt_pkg::item_t item,
	output kvt_pkg::push_t push
);

	localparam logic [2:0] M_SKIP     = 3'd0;
	localparam logic [2:0] M_KEY      = 3'd1;
	localparam logic [2:0] M_AFTER_EQ = 3'd3;
	localparam logic [2:0] M_UNQ      = 3'd4;
	localparam logic [2:0] M_QUO      = 3'd5;
	localparam logic [2:0] M_ESC_UNQ  = 3'd6;
	localparam logic [2:0] M_ESC_QUO  = 3'd7;

	localparam logic [kvt_pkg::KeyLenW-1:0] KeyMax =
		kvt_pkg::KeyLenW'(kvt_pkg::KEY_CAPACITY - 1);
	localparam logic [kvt_pkg::ValLenW-1:0] ValMax =
		kvt_pkg::ValLenW'(kvt_pkg::VALUE_CAPACITY - 1);

	logic [2:0]                   mode_q, mode_n;
	logic [kvt_pkg::KeyLenW-1:0]  klen_q, klen_n;
	logic [kvt_pkg::ValLenW-1:0]  vlen_q, vlen_n;

	kvt_pkg::token_t res [2];
	logic [1:0]      cnt;
	logic [7:0]      b;
	logic            last;
	logic            quoted;
	logic [7:0]      vb;

	always_comb begin
		b      = item.data_byte;
		last   = item.end_of_string;
		mode_n = mode_q;
		klen_n = klen_q;
		vlen_n = vlen_q;
		cnt    = 2'd0;
		quoted = 1'b0;
		vb     = b;
		res[0] = '0;
		res[1] = '0;

		unique case (mode_q)
			M_SKIP, M_KEY: begin
				if (mode_q == M_SKIP && kvt_pkg::is_ws(b)) begin
					// Still between tokens.
				end else if (b == kvt_pkg::CH_EQUAL) begin
					mode_n = M_AFTER_EQ;
					vlen_n = '0;
					if (mode_q == M_SKIP)
						klen_n = '0;
					if (last) begin
						res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_SKIP;
						klen_n = '0;
						vlen_n = '0;
					end
				end else if (kvt_pkg::is_ws(b)) begin
					res[cnt[0]] = '{kvt_pkg::KIND_DISCARD, 8'h00, 1'b0};
					cnt = cnt + 2'd1;
					mode_n = M_SKIP;
					klen_n = '0;
					vlen_n = '0;
				end else begin
					if (mode_q == M_SKIP) begin
						klen_n = '0;
						vlen_n = '0;
					end
					if (klen_n < KeyMax) begin
						res[cnt[0]] = '{kvt_pkg::KIND_KEY, b, 1'b0};
						cnt = cnt + 2'd1;
						klen_n = klen_n + 1'b1;
					end
					mode_n = M_KEY;
					if (last) begin
						res[cnt[0]] = '{kvt_pkg::KIND_DISCARD, 8'h00, 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_SKIP;
						klen_n = '0;
						vlen_n = '0;
					end
				end
			end
			M_AFTER_EQ, M_UNQ, M_QUO: begin
				quoted = (mode_q == M_QUO);
				if (mode_q == M_AFTER_EQ && kvt_pkg::is_ws(b)) begin
					if (last) begin
						res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_SKIP;
						klen_n = '0;
						vlen_n = '0;
					end
				end else if (mode_q == M_AFTER_EQ && b == kvt_pkg::CH_QUOTE) begin
					mode_n = M_QUO;
					if (last) begin
						res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_SKIP;
						klen_n = '0;
						vlen_n = '0;
					end
				end else if ((!quoted && kvt_pkg::is_ws(b)) ||
					(quoted && b == kvt_pkg::CH_QUOTE)) begin
					res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
					cnt = cnt + 2'd1;
					mode_n = M_SKIP;
					klen_n = '0;
					vlen_n = '0;
				end else if (b == kvt_pkg::CH_BSLASH && !last) begin
					mode_n = quoted ? M_ESC_QUO : M_ESC_UNQ;
				end else begin
					// A trailing backslash lands here and is kept literally.
					if (vlen_q < ValMax) begin
						res[cnt[0]] = '{kvt_pkg::KIND_VALUE, b, 1'b0};
						cnt = cnt + 2'd1;
						vlen_n = vlen_q + 1'b1;
					end
					mode_n = quoted ? M_QUO : M_UNQ;
					if (last) begin
						res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
						cnt = cnt + 2'd1;
						mode_n = M_SKIP;
						klen_n = '0;
						vlen_n = '0;
					end
				end
			end
			M_ESC_UNQ, M_ESC_QUO: begin
				vb = kvt_pkg::translate(b);
				if (vlen_q < ValMax) begin
					res[cnt[0]] = '{kvt_pkg::KIND_VALUE, vb, 1'b0};
					cnt = cnt + 2'd1;
					vlen_n = vlen_q + 1'b1;
				end
				mode_n = (mode_q == M_ESC_QUO) ? M_QUO : M_UNQ;
				if (last) begin
					res[cnt[0]] = '{kvt_pkg::KIND_DONE, 8'h00, 1'b0};
					cnt = cnt + 2'd1;
					mode_n = M_SKIP;
					klen_n = '0;
					vlen_n = '0;
				end
			end
			default: begin
				// Unused mode code falls back to idle.
				mode_n = M_SKIP;
				klen_n = '0;
				vlen_n = '0;
			end
		endcase

		// The end of a string always leaves the parser idle.
		if (last && cnt == 2'd0) begin
			mode_n = M_SKIP;
			klen_n = '0;
			vlen_n = '0;
		end

		if (cnt == 2'd1)
			res[0].run_last = 1'b1;
		else if (cnt == 2'd2)
			res[1].run_last = 1'b1;
	end

	assign push.count  = cnt;
	assign push.first  = res[0];
	assign push.second = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
			klen_q <= '0;
			vlen_q <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			klen_q <= klen_n;
			vlen_q <= vlen_n;
		end
	end

endmodule

FILE: design/kvt_queue.sv
// ----------------------------------------------------------------------------
// kvt_queue
// Four-entry result queue; takes up to two results per cycle, gives one unless tok_stall is high.
// ----------------------------------------------------------------------------
module kvt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_en,
	input  kvt_pkg::push_t  push,
	output logic            room,
	output logic            tok_valid,
	input  logic            tok_stall,
	output kvt_pkg::token_t tok_data
);

	kvt_pkg::token_t mem_q [4];
	logic [1:0]      wr_q;
	logic [1:0]      rd_q;
	logic [2:0]      count_q;
	logic [1:0]      n_push;
	logic            pop;

	assign n_push    = push_en ? push.count : 2'd0;
	assign pop       = tok_valid && !tok_stall;
	assign tok_valid = (count_q != 3'd0);
	assign tok_data  = mem_q[rd_q];
	// Room for the worst case of two results from one byte.
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= push.first;
		if (n_push == 2'd2)
			mem_q[wr_q + 2'd1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

endmodule
